[sv/iin_pkg.sv]
// Shared types, constants and tempering function for the impulse noise injector.
package iin_pkg;

	localparam int TW_N = 624;
	localparam int TW_M = 397;
	localparam int TW_IDX_W = $clog2(TW_N + 1);

	typedef logic [TW_IDX_W-1:0] tw_idx_t;

	localparam tw_idx_t TW_LAST_IDX = tw_idx_t'(TW_N - 1);
	localparam tw_idx_t TW_END      = tw_idx_t'(TW_N);
	localparam tw_idx_t TW_WRAP     = tw_idx_t'(TW_N - TW_M);
	localparam tw_idx_t TW_OFFS     = tw_idx_t'(TW_M);

	localparam logic [31:0] TW_MATRIX = 32'h9908_B0DF;
	localparam logic [31:0] TW_UPPER  = 32'h8000_0000;
	localparam logic [31:0] TW_LOWER  = 32'h7FFF_FFFF;
	localparam logic [31:0] SEED_MULT = 32'd1812433253;

	localparam logic [7:0] PIX_BLACK = 8'd0;
	localparam logic [7:0] PIX_WHITE = 8'd255;

	localparam int THR_W     = 33;
	localparam int CFG_W     = 33;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 1'b1;

	localparam logic [31:0] SEED_RESET = 32'd5489;

	typedef struct packed {
		logic [7:0] pix;
		logic       reseed;
	} iin_item_t;

	function automatic logic [31:0] tw_temper(input logic [31:0] x);
		logic [31:0] y;
		y = x;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & 32'h9D2C_5680);
		y = y ^ ((y << 15) & 32'hEFC6_0000);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

[sv/iin_front.sv]
// Front end: accepts pixels, marks reseeds, and queues them for the generator.
module iin_front import iin_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] pixel_in,
	input  logic       image_start,
	output logic       q_valid,
	output iin_item_t  q_item,
	input  logic       q_pop
);

	iin_item_t  slot_q [2];
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       seeded_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			seeded_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
				seeded_q <= 1'b1;
			end
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// no reseed on the first pixel ever seen still has to seed
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].pix    <= pixel_in;
			slot_q[wr_ptr_q].reseed <= image_start || !seeded_q;
		end
	end

endmodule

[sv/iin_back.sv]
// Back end: MT19937 state memory, seeding, twisting, draws and the output register.
module iin_back import iin_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  iin_item_t        q_item,
	output logic             q_pop,
	input  logic [THR_W-1:0] thr,
	input  logic [31:0]      seed,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       pixel_out,
	output logic             was_corrupted
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SEED0, ST_SEED, ST_TW_PRE, ST_TW_RUN, ST_TW_LAST, ST_DRAW, ST_USE
	} state_t;

	state_t      state_q;
	tw_idx_t     pos_q;
	tw_idx_t     k_q;
	tw_idx_t     tw_k_s1;
	logic        tw_wr_s1;
	logic        twrd_s1;
	logic [31:0] p_q;
	logic [31:0] cur_q;
	logic [7:0]  pix_q;
	logic        second_q;
	logic        out_valid_q;
	logic [7:0]  pixel_out_q;
	logic        corrupted_q;

	logic [31:0] tw_mem [TW_N];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	logic [31:0] word;
	logic        corrupt;
	logic        out_free;
	logic        out_load;
	logic [31:0] seed_x;
	logic [31:0] seed_next;
	logic [31:0] tw_y;
	logic [31:0] tw_new;
	tw_idx_t     nxt_k;
	tw_idx_t     far_k;
	logic        issue_draw;
	logic        tw_issue;
	logic        rd_a_en;
	tw_idx_t     rd_a_addr;
	logic        rd_b_en;
	logic        mem_we;
	tw_idx_t     mem_waddr;
	logic [31:0] mem_wdata;

	assign word      = tw_temper(rd_a_q);
	assign corrupt   = {1'b0, word} < thr;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_USE) && out_free && (second_q || !corrupt);
	assign seed_x    = p_q ^ (p_q >> 30);
	assign seed_next = 32'(seed_x * SEED_MULT) + 32'(k_q);
	assign tw_y      = (cur_q & TW_UPPER) | (rd_a_q & TW_LOWER);
	assign tw_new    = rd_b_q ^ (tw_y >> 1) ^ (tw_y[0] ? TW_MATRIX : 32'd0);
	assign nxt_k     = (k_q == TW_LAST_IDX) ? '0 : k_q + tw_idx_t'(1);
	assign far_k     = (k_q < TW_WRAP) ? k_q + TW_OFFS : k_q - TW_WRAP;

	assign q_pop         = (state_q == ST_IDLE) && q_valid;
	assign out_valid     = out_valid_q;
	assign pixel_out     = pixel_out_q;
	assign was_corrupted = corrupted_q;

	always_comb begin
		issue_draw = ((state_q == ST_IDLE) && q_valid && !q_item.reseed && (pos_q != TW_END))
			|| (state_q == ST_DRAW)
			|| ((state_q == ST_USE) && !second_q && corrupt && (pos_q != TW_END));
		tw_issue   = (state_q == ST_TW_PRE) || (state_q == ST_TW_RUN);
		rd_a_en    = issue_draw || tw_issue;
		if (issue_draw)
			rd_a_addr = pos_q;
		else if (state_q == ST_TW_PRE)
			rd_a_addr = '0;
		else
			rd_a_addr = nxt_k;
		rd_b_en = (state_q == ST_TW_RUN);
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		if (state_q == ST_SEED0) begin
			mem_we    = 1'b1;
			mem_wdata = seed;
		end else if (state_q == ST_SEED) begin
			mem_we    = 1'b1;
			mem_waddr = k_q;
			mem_wdata = seed_next;
		end else if (tw_wr_s1) begin
			mem_we    = 1'b1;
			mem_waddr = tw_k_s1;
			mem_wdata = tw_new;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			tw_mem[mem_waddr] <= mem_wdata;
		if (rd_a_en)
			rd_a_q <= tw_mem[rd_a_addr];
		if (rd_b_en)
			rd_b_q <= tw_mem[far_k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= TW_END;
			tw_wr_s1    <= 1'b0;
			twrd_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			tw_wr_s1 <= (state_q == ST_TW_RUN);
			twrd_s1  <= tw_issue;
			if (twrd_s1)
				cur_q <= rd_a_q;
			if (issue_draw)
				pos_q <= pos_q + tw_idx_t'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						pix_q    <= q_item.pix;
						second_q <= 1'b0;
						if (q_item.reseed)
							state_q <= ST_SEED0;
						else if (pos_q == TW_END)
							state_q <= ST_TW_PRE;
						else
							state_q <= ST_USE;
					end
				end
				ST_SEED0: begin
					p_q     <= seed;
					k_q     <= tw_idx_t'(1);
					state_q <= ST_SEED;
				end
				ST_SEED: begin
					p_q <= seed_next;
					if (k_q == TW_LAST_IDX) begin
						pos_q   <= TW_END;
						state_q <= ST_TW_PRE;
					end else begin
						k_q <= k_q + tw_idx_t'(1);
					end
				end
				ST_TW_PRE: begin
					k_q     <= '0;
					state_q <= ST_TW_RUN;
				end
				ST_TW_RUN: begin
					tw_k_s1 <= k_q;
					if (k_q == TW_LAST_IDX)
						state_q <= ST_TW_LAST;
					else
						k_q <= nxt_k;
				end
				ST_TW_LAST: begin
					pos_q   <= '0;
					state_q <= ST_DRAW;
				end
				ST_DRAW: begin
					state_q <= ST_USE;
				end
				ST_USE: begin
					if (!second_q) begin
						if (!corrupt) begin
							if (out_free) begin
								pixel_out_q <= pix_q;
								corrupted_q <= 1'b0;
								state_q     <= ST_IDLE;
							end
						end else begin
							second_q <= 1'b1;
							if (pos_q == TW_END)
								state_q <= ST_TW_PRE;
						end
					end else if (out_free) begin
						pixel_out_q <= word[31] ? PIX_WHITE : PIX_BLACK;
						corrupted_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/impulse_noise_injector.sv]
// Top level of the salt-and-pepper impulse noise injector.
//
// Input channel (in_valid/in_stall) takes one 8-bit gray pixel per transaction,
// with image_start high on the first pixel of an image. Output channel
// (out_valid/out_stall) returns one pixel per input: unchanged, 0 or 255,
// flagged by was_corrupted. cfg_we/cfg_index/cfg_data write the threshold
// (index 0, probability times 2^32, 33 bits) and the seed (index 1).
// A two-entry queue sits between input and generator, and a result register
// sits at the output, so input keeps flowing while a result waits.
// A passing pixel takes one draw, a corrupted one a second draw; each draw is
// a registered read of the state memory followed by tempering.
// Every 624 draws the state memory is twisted, one word a cycle.
// A pixel that reseeds first walks the 624-word memory, then twists.
// The back end finishes one pixel before it pops the next from the queue.
// Reset clears the queue, output register and generator status; the first
// pixel after reset seeds the generator even without image_start. A stalled
// output holds its result; the back end waits and the queue fills, then
// in_stall rises.
module impulse_noise_injector import iin_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           pixel_in,
	input  logic                 image_start,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           pixel_out,
	output logic                 was_corrupted,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [THR_W-1:0] thr_q;
	logic [31:0]      seed_q;
	logic             q_valid;
	logic             q_pop;
	iin_item_t        q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESH: thr_q  <= cfg_data[THR_W-1:0];
				CFG_SEED:   seed_q <= cfg_data[31:0];
				default:    thr_q  <= thr_q;
			endcase
		end
	end

	iin_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_in    (pixel_in),
		.image_start (image_start),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	iin_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.thr           (thr_q),
		.seed          (seed_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_out     (pixel_out),
		.was_corrupted (was_corrupted)
	);

endmodule

[sv/iin_checker.sv]
// Port-level checker for the impulse noise injector, bound to the top level.
module iin_checker import iin_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] pixel_in,
	input logic       image_start,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] pixel_out,
	input logic       was_corrupted,
	input logic       cfg_we
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(was_corrupted))
		else $error("stalled result changed or dropped");

	a_impulse_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_corrupted |-> (pixel_out == PIX_BLACK) || (pixel_out == PIX_WHITE))
		else $error("corrupted pixel is not an impulse");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(pixel_in) && $stable(image_start))
		else $error("stalled input transaction changed or dropped");

	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_valid && !out_valid)
		else $error("register write while a transaction is in flight");

endmodule

bind impulse_noise_injector iin_checker u_iin_checker (.*);
